/* rtl/core/ogi_pkg.sv */
// Shared types, codes and constants of the occupancy grid inflation core.
package ogi_pkg;

   // Field and counter widths
   localparam int DIM_W   = 9;
   localparam int CNT_W   = 18;
   localparam int K_W     = 5;
   localparam int RAD_W   = 4;
   localparam int CELL_W  = 8;
   localparam int IDX_W   = 3;
   localparam int RECIP_S = 14;
   localparam int RECIP_W = 15;

   // Cell marks and register reset values
   localparam logic [CELL_W-1:0] OCCUPIED_MARK   = 8'd100;
   localparam logic [CELL_W-1:0] INFLATED_MARK   = 8'd254;
   localparam logic [CELL_W-1:0] THRESHOLD_RESET = 8'd80;
   localparam logic [DIM_W-1:0]  WIDTH_RESET     = 9'd256;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 9'd256;
   localparam logic [K_W-1:0]    FACTOR_RESET    = 5'd1;
   localparam logic [RAD_W-1:0]  RADIUS_RESET    = 4'd2;
   localparam logic [DIM_W-1:0]  LIMIT_RESET     = 9'd4;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] CSR_FACTOR = 3'd2;
   localparam logic [IDX_W-1:0] CSR_RADIUS = 3'd3;
   localparam logic [IDX_W-1:0] CSR_LIMIT  = 3'd4;
   localparam logic [IDX_W-1:0] CSR_THRESH = 3'd5;

   // Command codes carried in tuser
   typedef enum logic [1:0] {
      FUNC_LOAD = 2'd0,
      FUNC_RUN  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   // Reciprocals ceil(2^14 / k) for the divide by the downsample factor
   localparam logic [RECIP_W-1:0] RECIP [32] = '{
      15'd16384, 15'd16384, 15'd8192, 15'd5462, 15'd4096, 15'd3277, 15'd2731, 15'd2341,
      15'd2048,  15'd1821,  15'd1639, 15'd1490, 15'd1366, 15'd1261, 15'd1171, 15'd1093,
      15'd1024,  15'd964,   15'd911,  15'd863,  15'd820,  15'd781,  15'd745,  15'd713,
      15'd683,   15'd656,   15'd631,  15'd607,  15'd586,  15'd565,  15'd547,  15'd529
   };

   // Controller states
   typedef enum logic [14:0] {
      ST_CLEAR   = 15'h0001,
      ST_IDLE    = 15'h0002,
      ST_READ    = 15'h0004,
      ST_DS_INIT = 15'h0008,
      ST_DS_RD   = 15'h0010,
      ST_DS_WT   = 15'h0020,
      ST_DS_WR   = 15'h0040,
      ST_FL_INIT = 15'h0080,
      ST_FL_RD   = 15'h0100,
      ST_FL_WT   = 15'h0200,
      ST_WIN     = 15'h0400,
      ST_FX_INIT = 15'h0800,
      ST_FX_RD   = 15'h1000,
      ST_FX_WR   = 15'h2000,
      ST_DONE    = 15'h4000
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_step;
      logic load_wr;
      logic rd_issue;
      logic rsp_read;
      logic rsp_run;
      logic ds_init;
      logic ds_rd;
      logic ds_acc;
      logic ds_wr;
      logic fl_init;
      logic fl_rd;
      logic win_init;
      logic win_step;
      logic cell_next;
      logic fx_rd;
      logic fx_wr;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic settle_busy;
      logic rsp_free;
      logic clr_last;
      logic ds_skip;
      logic res_empty;
      logic ds_blk_last;
      logic ds_all_last;
      logic obstacle;
      logic win_last;
      logic cell_last;
   } status_type;

endpackage

/* rtl/core/occupancy_grid_inflation_core.sv */
// Top level of the occupancy grid inflation core: controller plus datapath.
// Load word: one cell per cycle while idle, settled and with room for the answer. Read word:
// answer through the READ state and the output register (registered grid memory read port);
// no word is taken before the return to idle. Run word: reduce (k > 1), scan each cell and
// the (2R+1)^2 window of each obstacle, then mark; answer follows the last cell.
// Reset: synchronous; clears positions and loads register defaults, then a clearing pass over
// all MAX_WIDTH*MAX_HEIGHT addresses zeroes the grid and flag memories, with no word taken.
module occupancy_grid_inflation_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // cell_value[7:0]
   input  logic [1:0]                 req_tuser,   // func[1:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // cost_value[7:0]
   output logic                       rsp_tlast,
   output logic [0:0]                 rsp_tuser,   // run_done[0]
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ogi_pkg::IDX_W-1:0]  csr_index,
   input  logic [ogi_pkg::DIM_W-1:0]  csr_data
);
   import ogi_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Take register writes at once
   assign csr_ready = 1'b1;

   ogi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   ogi_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_data   (req_tdata),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Check that input is taken only with room for its answer
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready)) else $error("ready with output blocked");
   a_run_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 8'd0 && !rsp_tlast))
      else $error("run answer carries data");
   a_no_take_settling: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> !req_tready) else $error("word taken while dimensions settle");

endmodule

/* rtl/core/ogi_ctrl.sv */
// Sequencing state machine of the occupancy grid inflation core.
module ogi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  ogi_pkg::status_type  status,
   output ogi_pkg::cmd_type     cmd
);
   import ogi_pkg::*;

   state_type state_ff, state_in;
   logic      req_take;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      req_take   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = !status.settle_busy && status.rsp_free;
            req_take   = req_tready && req_tvalid;
            if (req_take) begin
               case (func_type'(req_tuser))
                  FUNC_LOAD: cmd.load_wr = 1'b1;
                  FUNC_RUN:  state_in = ST_DS_INIT;
                  FUNC_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DS_INIT: begin
            cmd.ds_init = 1'b1;
            state_in    = status.ds_skip ? ST_FL_INIT : ST_DS_RD;
         end
         ST_DS_RD: begin
            cmd.ds_rd = 1'b1;
            state_in  = ST_DS_WT;
         end
         ST_DS_WT: begin
            cmd.ds_acc = 1'b1;
            state_in   = status.ds_blk_last ? ST_DS_WR : ST_DS_RD;
         end
         ST_DS_WR: begin
            cmd.ds_wr = 1'b1;
            state_in  = status.ds_all_last ? ST_FL_INIT : ST_DS_RD;
         end
         ST_FL_INIT: begin
            cmd.fl_init = 1'b1;
            state_in    = status.res_empty ? ST_DONE : ST_FL_RD;
         end
         ST_FL_RD: begin
            cmd.fl_rd = 1'b1;
            state_in  = ST_FL_WT;
         end
         ST_FL_WT: begin
            if (status.obstacle) begin
               cmd.win_init = 1'b1;
               state_in     = ST_WIN;
            end else begin
               cmd.cell_next = 1'b1;
               state_in      = status.cell_last ? ST_FX_INIT : ST_FL_RD;
            end
         end
         ST_WIN: begin
            cmd.win_step = 1'b1;
            if (status.win_last) begin
               cmd.cell_next = 1'b1;
               state_in      = status.cell_last ? ST_FX_INIT : ST_FL_RD;
            end
         end
         ST_FX_INIT: begin
            cmd.fl_init = 1'b1;
            state_in    = ST_FX_RD;
         end
         ST_FX_RD: begin
            cmd.fx_rd = 1'b1;
            state_in  = ST_FX_WR;
         end
         ST_FX_WR: begin
            cmd.fx_wr     = 1'b1;
            cmd.cell_next = 1'b1;
            state_in      = status.cell_last ? ST_DONE : ST_FX_RD;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_run = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Check sequencing
   a_run_result_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_run |-> status.rsp_free) else $error("run word with output busy");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == ST_IDLE))
      else $error("word taken outside idle");
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> cmd.rsp_read) else $error("read answer missing");

endmodule

/* rtl/core/ogi_datapath.sv */
// Grid memories, configuration, counters and output register of the inflation core.
module ogi_datapath #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [ogi_pkg::IDX_W-1:0]  csr_index,
   input  logic [ogi_pkg::DIM_W-1:0]  csr_data,
   input  logic [ogi_pkg::CELL_W-1:0] req_data,
   input  logic                       rsp_tready,
   input  ogi_pkg::cmd_type           cmd,
   output ogi_pkg::status_type        status,
   output logic                       rsp_tvalid,
   output logic [ogi_pkg::CELL_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   output logic [0:0]                 rsp_tuser
);
   import ogi_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   // Configuration registers
   logic [DIM_W-1:0]        w_raw_ff, h_raw_ff, lim_ff;
   logic [K_W-1:0]          k_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic signed [CELL_W-1:0] thr_ff;
   logic [1:0]              settle_ff;

   // Derived dimensions
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [K_W-1:0]   k_eff;
   logic [RAD_W-1:0] rad_eff;
   logic [23:0]      prod_w, prod_h;
   logic [DIM_W-1:0] wq_ff, hq_ff;
   logic [CNT_W-1:0] rawn_ff, resn_ff, kw_ff;
   logic [12:0]      radw_ff;
   logic [7:0]       radsq_ff;

   // Memories
   logic [CELL_W-1:0] grid_mem [DEPTH];
   logic              near_mem [DEPTH];
   logic [CELL_W-1:0] g_rd_ff;
   logic              near_rd_ff;
   logic              g_we, n_we, n_wdata;
   logic [AW-1:0]     g_waddr, g_raddr, n_waddr;
   logic [CELL_W-1:0] g_wdata;
   logic [AW-1:0]     clr_ptr_ff;

   // Positions
   logic [CNT_W-1:0] lp_ff, rp_ff, la, la_nx, ra, ra_nx;

   // Reduction counters
   logic [CNT_W-1:0] row_base_ff, col_off_ff, line_ff, out_ptr_ff;
   logic [K_W-1:0]   ds_i_ff, ds_j_ff;
   logic [DIM_W-1:0] ds_c_ff, ds_r_ff;
   logic             any_ff;

   // Scan and window counters
   logic [CNT_W-1:0]  cell_ptr_ff;
   logic [DIM_W-1:0]  cell_r_ff, cell_c_ff;
   logic signed [5:0] dy_ff, dx_ff, rad_s;
   logic [8:0]        sqy_ff, sqx_ff;
   logic [9:0]        sq_sum;
   logic signed [CNT_W:0] wrow_ff, waddr_s;
   logic signed [10:0] win_y, win_x;
   logic              win_ok;
   logic              cell_low;

   // Output register
   logic              rsp_valid_ff, rd_empty_ff, rd_last_ff;
   logic [CELL_W-1:0] rsp_data_ff;
   logic              rsp_last_ff, rsp_run_ff;
   logic              rsp_free;

   // Write configuration and settle the derived dimensions
   always_ff @(posedge clock) begin
      if (reset) begin
         w_raw_ff  <= WIDTH_RESET;
         h_raw_ff  <= HEIGHT_RESET;
         k_ff      <= FACTOR_RESET;
         rad_ff    <= RADIUS_RESET;
         lim_ff    <= LIMIT_RESET;
         thr_ff    <= THRESHOLD_RESET;
         settle_ff <= 2'd2;
      end else begin
         if (csr_valid) begin
            settle_ff <= 2'd2;
            case (csr_index)
               CSR_WIDTH:  w_raw_ff <= csr_data;
               CSR_HEIGHT: h_raw_ff <= csr_data;
               CSR_FACTOR: k_ff     <= csr_data[K_W-1:0];
               CSR_RADIUS: rad_ff   <= csr_data[RAD_W-1:0];
               CSR_LIMIT:  lim_ff   <= csr_data;
               CSR_THRESH: thr_ff   <= csr_data[CELL_W-1:0];
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // Clamp the configuration
   always_comb begin
      eff_w   = ({23'd0, w_raw_ff} > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : w_raw_ff;
      eff_h   = ({23'd0, h_raw_ff} > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : h_raw_ff;
      k_eff   = (k_ff == '0) ? K_W'(1) : k_ff;
      rad_eff = ({28'd0, rad_ff} > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : rad_ff;
      prod_w  = {15'd0, eff_w} * {9'd0, RECIP[k_eff]};
      prod_h  = {15'd0, eff_h} * {9'd0, RECIP[k_eff]};
   end

   // Divide by the factor, then form counts and window offsets
   always_ff @(posedge clock) begin
      wq_ff    <= prod_w[RECIP_S+DIM_W-1:RECIP_S];
      hq_ff    <= prod_h[RECIP_S+DIM_W-1:RECIP_S];
      rawn_ff  <= CNT_W'(eff_w * eff_h);
      kw_ff    <= CNT_W'(k_eff * eff_w);
      resn_ff  <= CNT_W'(wq_ff * hq_ff);
      radw_ff  <= 13'(rad_eff * wq_ff);
      radsq_ff <= 8'(rad_eff * rad_eff);
   end

   // Wrap the load and read positions
   always_comb begin
      la    = (lp_ff >= rawn_ff) ? '0 : lp_ff;
      la_nx = la + CNT_W'(1);
      ra    = (rp_ff >= resn_ff) ? '0 : rp_ff;
      ra_nx = ra + CNT_W'(1);
   end

   // Window geometry
   always_comb begin
      rad_s    = $signed({2'b00, rad_eff});
      win_y    = $signed({2'b00, cell_r_ff}) + {{5{dy_ff[5]}}, dy_ff};
      win_x    = $signed({2'b00, cell_c_ff}) + {{5{dx_ff[5]}}, dx_ff};
      waddr_s  = wrow_ff + {{(CNT_W-5){dx_ff[5]}}, dx_ff};
      sq_sum   = {1'b0, sqy_ff} + {1'b0, sqx_ff};
      win_ok   = (win_y >= 0) && (win_y < $signed({2'b00, hq_ff})) &&
                 (win_x >= 0) && (win_x < $signed({2'b00, wq_ff})) &&
                 (sq_sum < {1'b0, lim_ff});
      cell_low = ($signed(g_rd_ff) <= 0);
   end

   // Drive memory ports
   always_comb begin
      g_we    = 1'b0;
      g_waddr = clr_ptr_ff;
      g_wdata = '0;
      if (cmd.clr_step) begin
         g_we = 1'b1;
      end else if (cmd.load_wr && rawn_ff != '0) begin
         g_we    = 1'b1;
         g_waddr = AW'(la);
         g_wdata = req_data;
      end else if (cmd.ds_wr) begin
         g_we    = 1'b1;
         g_waddr = AW'(out_ptr_ff);
         g_wdata = any_ff ? OCCUPIED_MARK : '0;
      end else if (cmd.fx_wr && near_rd_ff && cell_low) begin
         g_we    = 1'b1;
         g_waddr = AW'(cell_ptr_ff);
         g_wdata = INFLATED_MARK;
      end
      if (cmd.rd_issue) begin
         g_raddr = AW'(ra);
      end else if (cmd.ds_rd) begin
         g_raddr = AW'(line_ff + CNT_W'(ds_j_ff));
      end else begin
         g_raddr = AW'(cell_ptr_ff);
      end
      n_we    = 1'b0;
      n_waddr = clr_ptr_ff;
      n_wdata = 1'b0;
      if (cmd.clr_step) begin
         n_we = 1'b1;
      end else if (cmd.win_step && win_ok) begin
         n_we    = 1'b1;
         n_waddr = AW'(waddr_s);
         n_wdata = 1'b1;
      end else if (cmd.fx_wr) begin
         n_we    = 1'b1;
         n_waddr = AW'(cell_ptr_ff);
      end
   end

   // Access the memories
   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_waddr] <= g_wdata;
      g_rd_ff <= grid_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (n_we) near_mem[n_waddr] <= n_wdata;
      near_rd_ff <= near_mem[AW'(cell_ptr_ff)];
   end

   // Advance clearing and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         lp_ff      <= '0;
         rp_ff      <= '0;
      end else begin
         if (cmd.clr_step) clr_ptr_ff <= clr_ptr_ff + AW'(1);
         if (cmd.load_wr && rawn_ff != '0) lp_ff <= (la_nx >= rawn_ff) ? '0 : la_nx;
         if (cmd.rd_issue && resn_ff != '0) rp_ff <= (ra_nx >= resn_ff) ? '0 : ra_nx;
         if (cmd.rsp_run) begin
            lp_ff <= '0;
            rp_ff <= '0;
         end
      end
   end

   // Step the reduction blocks
   always_ff @(posedge clock) begin
      if (cmd.ds_init) begin
         row_base_ff <= '0;
         col_off_ff  <= '0;
         line_ff     <= '0;
         out_ptr_ff  <= '0;
         ds_i_ff     <= '0;
         ds_j_ff     <= '0;
         ds_c_ff     <= '0;
         ds_r_ff     <= '0;
         any_ff      <= 1'b0;
      end
      if (cmd.ds_acc) begin
         any_ff <= any_ff | ($signed(g_rd_ff) > 0);
         if (ds_j_ff == k_eff - K_W'(1)) begin
            ds_j_ff <= '0;
            if (ds_i_ff != k_eff - K_W'(1)) begin
               ds_i_ff <= ds_i_ff + K_W'(1);
               line_ff <= line_ff + CNT_W'(eff_w);
            end
         end else begin
            ds_j_ff <= ds_j_ff + K_W'(1);
         end
      end
      if (cmd.ds_wr) begin
         any_ff     <= 1'b0;
         ds_i_ff    <= '0;
         ds_j_ff    <= '0;
         out_ptr_ff <= out_ptr_ff + CNT_W'(1);
         if (ds_c_ff == wq_ff - DIM_W'(1)) begin
            ds_c_ff     <= '0;
            ds_r_ff     <= ds_r_ff + DIM_W'(1);
            col_off_ff  <= '0;
            row_base_ff <= row_base_ff + kw_ff;
            line_ff     <= row_base_ff + kw_ff;
         end else begin
            ds_c_ff    <= ds_c_ff + DIM_W'(1);
            col_off_ff <= col_off_ff + CNT_W'(k_eff);
            line_ff    <= row_base_ff + col_off_ff + CNT_W'(k_eff);
         end
      end
   end

   // Step the cell scan and the obstacle window
   always_ff @(posedge clock) begin
      if (cmd.fl_init) begin
         cell_ptr_ff <= '0;
         cell_r_ff   <= '0;
         cell_c_ff   <= '0;
      end
      if (cmd.cell_next) begin
         cell_ptr_ff <= cell_ptr_ff + CNT_W'(1);
         if (cell_c_ff == wq_ff - DIM_W'(1)) begin
            cell_c_ff <= '0;
            cell_r_ff <= cell_r_ff + DIM_W'(1);
         end else begin
            cell_c_ff <= cell_c_ff + DIM_W'(1);
         end
      end
      if (cmd.win_init) begin
         dy_ff   <= -rad_s;
         dx_ff   <= -rad_s;
         sqy_ff  <= {1'b0, radsq_ff};
         sqx_ff  <= {1'b0, radsq_ff};
         wrow_ff <= $signed({1'b0, cell_ptr_ff}) - $signed((CNT_W+1)'(radw_ff));
      end
      if (cmd.win_step) begin
         if (dx_ff == rad_s) begin
            dx_ff   <= -rad_s;
            sqx_ff  <= {1'b0, radsq_ff};
            dy_ff   <= dy_ff + 6'sd1;
            sqy_ff  <= sqy_ff + {{2{dy_ff[5]}}, dy_ff, 1'b1};
            wrow_ff <= wrow_ff + $signed((CNT_W+1)'(wq_ff));
         end else begin
            dx_ff  <= dx_ff + 6'sd1;
            sqx_ff <= sqx_ff + {{2{dx_ff[5]}}, dx_ff, 1'b1};
         end
      end
   end

   // Hold the output word
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_read || cmd.rsp_run) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rd_empty_ff <= (resn_ff == '0);
         rd_last_ff  <= (ra == resn_ff - CNT_W'(1));
      end
      if (cmd.rsp_read) begin
         rsp_data_ff <= rd_empty_ff ? '0 : g_rd_ff;
         rsp_last_ff <= rd_empty_ff | rd_last_ff;
         rsp_run_ff  <= 1'b0;
      end else if (cmd.rsp_run) begin
         rsp_data_ff <= '0;
         rsp_last_ff <= 1'b0;
         rsp_run_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_run_ff;

   // Report status
   always_comb begin
      status.settle_busy = (settle_ff != 2'd0);
      status.rsp_free    = rsp_free;
      status.clr_last    = (clr_ptr_ff == AW'(DEPTH - 1));
      status.ds_skip     = (k_eff == K_W'(1)) || (resn_ff == '0);
      status.res_empty   = (resn_ff == '0);
      status.ds_blk_last = (ds_i_ff == k_eff - K_W'(1)) && (ds_j_ff == k_eff - K_W'(1));
      status.ds_all_last = (ds_c_ff == wq_ff - DIM_W'(1)) && (ds_r_ff == hq_ff - DIM_W'(1));
      status.obstacle    = ($signed(g_rd_ff) > thr_ff);
      status.win_last    = (dx_ff == rad_s) && (dy_ff == rad_s);
      status.cell_last   = (cell_ptr_ff == resn_ff - CNT_W'(1));
   end

   // Check datapath rules
   a_mark_needs_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.fx_wr && g_we) |-> near_rd_ff) else $error("inflation without flag");
   a_window_in_grid: assert property (@(posedge clock) disable iff (reset)
      (cmd.win_step && win_ok) |-> (waddr_s >= 0 && waddr_s < $signed({1'b0, resn_ff})))
      else $error("window write outside grid");
   a_output_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_read || cmd.rsp_run) |-> rsp_free) else $error("output word overrun");

endmodule

/* dv/tb_occupancy_grid_inflation_core.sv */
// Self-checking testbench of the occupancy grid inflation core with an inline grid predictor.
module tb_occupancy_grid_inflation_core;
   import ogi_pkg::*;

   localparam int GRID_DEPTH = 65536;
   localparam int IDLE_LIMIT = 3000000;
   localparam int LONG_HOLD  = 2000;

   typedef struct {
      func_type   func;
      logic [7:0] data;
   } cmd_word_t;

   typedef struct {
      logic [7:0] cost;
      logic       last;
      logic       done;
   } cost_word_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // cell_value[7:0]
   logic [1:0]       req_tuser = '0;   // func[1:0]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // cost_value[7:0]
   logic             rsp_tlast;
   logic [0:0]       rsp_tuser;        // run_done[0]
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0] csr_data = '0;

   // Stimulus and scoreboard storage
   cmd_word_t  cmd_queue[$];
   cost_word_t cost_queue[$];
   logic       req_fire = 1'b0;
   int         errors = 0;
   int         cells_checked = 0;
   int         runs_checked = 0;
   int         words_sent = 0;
   int         idle_cycles = 0;
   int         gap_left = 0;
   int         burst_left = 0;
   int         stall_mode = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   logic       hold_request = 1'b0;

   // Predictor state
   logic [7:0] grid_mem[GRID_DEPTH];
   logic [7:0] block_mem[GRID_DEPTH];
   logic       near_mem[GRID_DEPTH];
   int         load_pos = 0;
   int         read_pos = 0;
   int         cfg_width = 256;
   int         cfg_height = 256;
   int         cfg_factor = 1;
   int         cfg_radius = 2;
   int         cfg_limit = 4;
   logic [7:0] cfg_thresh = THRESHOLD_RESET;

   occupancy_grid_inflation_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int clip_width();
      return (cfg_width > 256) ? 256 : cfg_width;
   endfunction

   function automatic int clip_height();
      return (cfg_height > 256) ? 256 : cfg_height;
   endfunction

   function automatic int clip_factor();
      return (cfg_factor == 0) ? 1 : cfg_factor;
   endfunction

   function automatic void write_register(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      case (idx)
         CSR_WIDTH:  cfg_width  = int'(value);
         CSR_HEIGHT: cfg_height = int'(value);
         CSR_FACTOR: cfg_factor = int'(value[4:0]);
         CSR_RADIUS: cfg_radius = int'(value[3:0]);
         CSR_LIMIT:  cfg_limit  = int'(value);
         CSR_THRESH: cfg_thresh = value[7:0];
         default: ;
      endcase
   endfunction

   // Reduce by the block factor, then mark free cells near obstacles
   function automatic void inflate_grid();
      int raw_w, k, w, h, thr, y, x;
      logic any;
      raw_w = clip_width();
      k = clip_factor();
      w = raw_w / k;
      h = clip_height() / k;
      if (k > 1) begin
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
               any = 1'b0;
               for (int i = 0; i < k; i++)
                  for (int j = 0; j < k; j++)
                     if ($signed(grid_mem[(r*k+i)*raw_w + c*k + j]) > 0) any = 1'b1;
               block_mem[r*w+c] = any ? OCCUPIED_MARK : 8'd0;
            end
         end
         for (int i = 0; i < w*h; i++) grid_mem[i] = block_mem[i];
      end
      thr = $signed(cfg_thresh);
      for (int i = 0; i < w*h; i++) near_mem[i] = 1'b0;
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (int'($signed(grid_mem[r*w+c])) > thr) begin
               for (int dy = -cfg_radius; dy <= cfg_radius; dy++) begin
                  for (int dx = -cfg_radius; dx <= cfg_radius; dx++) begin
                     y = r + dy;
                     x = c + dx;
                     if (y >= 0 && y < h && x >= 0 && x < w && dy*dy + dx*dx < cfg_limit)
                        near_mem[y*w+x] = 1'b1;
                  end
               end
            end
         end
      end
      for (int i = 0; i < w*h; i++)
         if (near_mem[i] && $signed(grid_mem[i]) <= 0) grid_mem[i] = INFLATED_MARK;
   endfunction

   // Advance the predictor by one accepted command word
   function automatic void predict_word(cmd_word_t word);
      cost_word_t res;
      int n;
      case (word.func)
         FUNC_LOAD: begin
            n = clip_width() * clip_height();
            if (n != 0) begin
               if (load_pos >= n) load_pos = 0;
               grid_mem[load_pos] = word.data;
               load_pos++;
               if (load_pos >= n) load_pos = 0;
            end
         end
         FUNC_RUN: begin
            inflate_grid();
            load_pos = 0;
            read_pos = 0;
            res = '{cost: 8'd0, last: 1'b0, done: 1'b1};
            cost_queue = {cost_queue, res};
         end
         FUNC_READ: begin
            n = (clip_width() / clip_factor()) * (clip_height() / clip_factor());
            if (n == 0) begin
               res = '{cost: 8'd0, last: 1'b1, done: 1'b0};
            end else begin
               if (read_pos >= n) read_pos = 0;
               res = '{cost: grid_mem[read_pos], last: read_pos == n-1, done: 1'b0};
               read_pos++;
               if (read_pos >= n) read_pos = 0;
            end
            cost_queue = {cost_queue, res};
         end
         default: ;
      endcase
   endfunction

   // Take accepted words, check results, count idle cycles
   always @(posedge clock) begin
      cost_word_t exp_word;
      logic       busy;
      busy = 1'b0;
      req_fire <= req_tvalid && req_tready;
      if (!reset && csr_valid && csr_ready) begin
         write_register(csr_index, csr_data);
         busy = 1'b1;
      end
      if (!reset && req_tvalid && req_tready) begin
         predict_word(cmd_queue.pop_front());
         busy = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         busy = 1'b1;
         if (cost_queue.size() == 0) begin
            $display("%0t: unexpected result word cost=%0d last=%0b done=%0b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            exp_word = cost_queue.pop_front();
            if (rsp_tdata !== exp_word.cost || rsp_tlast !== exp_word.last ||
                rsp_tuser[0] !== exp_word.done) begin
               $display("%0t: mismatch expected cost=%0d last=%0b done=%0b, got %0d %0b %0b",
                        $time, exp_word.cost, exp_word.last, exp_word.done,
                        rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end
            if (exp_word.done) runs_checked++;
            else cells_checked++;
         end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present command words in bursts; hold a word until it is taken
   always @(negedge clock) begin
      if (!(req_tvalid && !req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= cmd_queue[0].data;
            req_tuser  <= cmd_queue[0].func;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result side in changing patterns, with one long hold on request
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 80);
      end else begin
         stall_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic drain();
      while (cmd_queue.size() != 0 || cost_queue.size() != 0 || req_tvalid) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[DIM_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(int w, int h, int k, int rad, int lim, int thr);
      drain();
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      csr_write(CSR_FACTOR, k);
      csr_write(CSR_RADIUS, rad);
      csr_write(CSR_LIMIT, lim);
      csr_write(CSR_THRESH, thr & 8'hFF);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_word(func_type f, logic [7:0] value);
      cmd_word_t word;
      word.func = f;
      word.data = value;
      cmd_queue = {cmd_queue, word};
      words_sent++;
   endtask

   function automatic logic [7:0] pick_cell();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd100;
         2: return 8'd127;
         3: return 8'h80;
         4: return 8'($urandom_range(128, 255));
         5: return 8'($urandom_range(1, 127));
         default: return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
      endcase
   endfunction

   // Load a map, run, and read the result, with optional noise words
   task automatic map_pass(int loads, int reads, logic noisy);
      for (int i = 0; i < loads; i++) begin
         push_word(FUNC_LOAD, pick_cell());
         if (noisy && $urandom_range(0, 15) == 0)
            push_word(FUNC_NOP, 8'($urandom_range(0, 255)));
      end
      push_word(FUNC_RUN, 8'($urandom_range(0, 255)));
      for (int i = 0; i < reads; i++) push_word(FUNC_READ, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int w, h, k, n;
      logic [7:0] corner_vals[12];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: readout of the cleared grid at reset settings
      push_word(FUNC_READ, 8'hFF);
      push_word(FUNC_READ, 8'h00);
      // Directed: all edge cell values in a small raw map, with wrap of the readout
      configure(4, 3, 1, 2, 5, 80);
      corner_vals = '{8'd0, 8'd127, 8'h80, 8'hFF, 8'd100, 8'd81, 8'd80, 8'd1, 8'd0, 8'h81,
                      8'd0, 8'd0};
      foreach (corner_vals[i]) push_word(FUNC_LOAD, corner_vals[i]);
      push_word(FUNC_NOP, 8'hA5);
      push_word(FUNC_RUN, 8'h5A);
      for (int i = 0; i < 13; i++) push_word(FUNC_READ, 8'd0);
      // Directed: empty grid ignores loads and reads answer as last
      configure(0, 5, 1, 15, 256, -128);
      push_word(FUNC_LOAD, 8'd7);
      push_word(FUNC_RUN, 8'd0);
      push_word(FUNC_READ, 8'd0);
      push_word(FUNC_READ, 8'd0);
      // Directed: zero factor acts as one, zero limit never marks, lowest threshold
      configure(3, 2, 0, 0, 0, -128);
      map_pass(6, 7, 1'b0);
      // Directed: oversize width, factor of 16, largest radius, limit of 256, long result hold
      configure(300, 256, 16, 15, 256, 0);
      map_pass(40, 0, 1'b0);
      drain();
      hold_request = 1'b1;
      for (int i = 0; i < 257; i++) push_word(FUNC_READ, 8'd0);
      // Directed: factor larger than the map gives an empty result
      configure(5, 5, 8, 1, 2, 127);
      map_pass(25, 2, 1'b0);

      // Random maps of small size
      while (words_sent < 1850) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 12);
         k = ($urandom_range(0, 2) != 0) ? 1 : $urandom_range(0, 4);
         configure(w, h, k, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, 3),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 256) : $urandom_range(1, 10),
                   ($urandom_range(0, 1) == 0) ? 80 : $urandom_range(0, 255) - 128);
         n = (w / ((k == 0) ? 1 : k)) * (h / ((k == 0) ? 1 : k));
         map_pass(w*h + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 0),
                  n + $urandom_range(0, 2), 1'b1);
         if ($urandom_range(0, 5) == 0)
            for (int i = 0; i < 4; i++) push_word(func_type'($urandom_range(0, 3)), pick_cell());
      end

      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d command words: %0d cells read, %0d runs checked.",
               words_sent, cells_checked, runs_checked);
      if (errors == 0 && cost_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
